@@ src/fpmq_pkg.sv @@
// ----------------------------------------------------------------------------
// fpmq_pkg
// Shared operation codes, field widths and controller/datapath interface types
// for the multi-level strict-priority message queue.
// ----------------------------------------------------------------------------
package fpmq_pkg;

    localparam int LVL_W = 3;
    localparam int SND_W = 16;
    localparam int PAY_W = 32;
    localparam int CNT_W = 6;
    localparam int ENT_W = SND_W + PAY_W;

    typedef enum logic [1:0] {
        OP_SEND     = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_PROMOTE  = 2'd2,
        OP_ANNOUNCE = 2'd3
    } t_op;

    typedef logic [LVL_W-1:0] t_lvl;

    typedef struct packed {
        logic load;
        logic send;
        logic lvl_start;
        logic pop;
        logic push;
        logic ann_pop;
        logic ann_emit;
        logic final_pop;
        t_lvl lvl;
    } t_cmd;

    typedef struct packed {
        logic fill_zero;
        logic k_last;
        logic any_nonempty;
        logic out_free;
    } t_stat;

endpackage

@@ src/five_level_priority_message_queue.sv @@
// ----------------------------------------------------------------------------
// five_level_priority_message_queue
// Strict-priority queue of FIFO levels with send, remove, promote, announce.
// Send writes one entry; remove walks every stored entry (up to 80) and promote
// every entry below the top level, level by level, through the single-port entry
// memory read/write loop. Announce pops one item at a time, gated by the output
// register.
// Reset clears every level to empty; the entry memory is not cleared.
// ----------------------------------------------------------------------------
module five_level_priority_message_queue #(
    parameter int LEVEL_DEPTH = 16,
    parameter int NUM_LEVELS  = 5,
    parameter int MAX_POPS    = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_operation,
    input  logic [fpmq_pkg::SND_W-1:0] i_sender_id,
    input  logic [fpmq_pkg::LVL_W-1:0] i_level,
    input  logic [fpmq_pkg::PAY_W-1:0] i_payload,
    input  logic [fpmq_pkg::CNT_W-1:0] i_count,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [fpmq_pkg::SND_W-1:0] o_out_sender,
    output logic [fpmq_pkg::LVL_W-1:0] o_out_level,
    output logic [fpmq_pkg::PAY_W-1:0] o_out_payload,
    output logic                       o_last
);
    import fpmq_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    t_op   op;

    assign op = t_op'(i_operation);

    fpmq_ctrl #(
        .NUM_LEVELS (NUM_LEVELS),
        .MAX_POPS   (MAX_POPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (op),
        .i_count     (i_count),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fpmq_dp #(
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_operation   (op),
        .i_sender_id   (i_sender_id),
        .i_level       (i_level),
        .i_payload     (i_payload),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_sender  (o_out_sender),
        .o_out_level   (o_out_level),
        .o_out_payload (o_out_payload),
        .o_last        (o_last)
    );

    a_push_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> $past(cmd.pop))
        else $error("push without preceding pop");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.send, cmd.lvl_start, cmd.pop, cmd.push, cmd.ann_pop, cmd.ann_emit}))
        else $error("more than one datapath action in a cycle");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ann_emit |-> stat.out_free)
        else $error("result loaded over a pending item");

endmodule

@@ src/fpmq_dp.sv @@
// ----------------------------------------------------------------------------
// fpmq_dp
// Datapath: entry memory, per-level head and fill registers, walk counter,
// priority select and the registered result stage.
// ----------------------------------------------------------------------------
module fpmq_dp #(
    parameter int LEVEL_DEPTH = 16,
    parameter int NUM_LEVELS  = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fpmq_pkg::t_op                 i_operation,
    input  logic [fpmq_pkg::SND_W-1:0]    i_sender_id,
    input  logic [fpmq_pkg::LVL_W-1:0]    i_level,
    input  logic [fpmq_pkg::PAY_W-1:0]    i_payload,
    input  fpmq_pkg::t_cmd                i_cmd,
    output fpmq_pkg::t_stat               o_stat,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [fpmq_pkg::SND_W-1:0]    o_out_sender,
    output logic [fpmq_pkg::LVL_W-1:0]    o_out_level,
    output logic [fpmq_pkg::PAY_W-1:0]    o_out_payload,
    output logic                          o_last
);
    import fpmq_pkg::*;

    localparam int LVW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int HW  = $clog2(LEVEL_DEPTH);
    localparam int FW  = $clog2(LEVEL_DEPTH + 1);
    localparam int TOT = NUM_LEVELS * LEVEL_DEPTH;
    localparam int AW  = $clog2(TOT);

    logic [ENT_W-1:0] r_mem [TOT];
    logic [HW-1:0]    r_head [NUM_LEVELS];
    logic [FW-1:0]    r_fill [NUM_LEVELS];
    t_op              r_op;
    logic [SND_W-1:0] r_who;
    t_lvl             r_lv;
    logic [PAY_W-1:0] r_pay;
    logic [FW-1:0]    r_k;
    logic [ENT_W-1:0] r_rdata;
    logic [LVW-1:0]   r_alvl;
    logic             r_alast;
    logic             r_ovalid;
    logic [SND_W-1:0] r_osnd;
    logic [LVL_W-1:0] r_olvl;
    logic [PAY_W-1:0] r_opay;
    logic             r_olast;

    logic [LVW-1:0]        cur, up, top, wl, rl, tgt;
    logic [NUM_LEVELS-1:0] nonempty;
    logic                  send_ok, keep, wr_en, rd_en;
    logic [FW:0]           sum;
    logic [HW-1:0]         tail;
    logic [ENT_W-1:0]      wdata;

    function automatic logic [AW-1:0] f_addr(logic [LVW-1:0] l, logic [HW-1:0] p);
        return AW'(int'(l) * LEVEL_DEPTH + int'(p));
    endfunction

    always_comb begin
        cur = i_cmd.lvl[LVW-1:0];
        up  = (i_cmd.lvl == t_lvl'(NUM_LEVELS - 1)) ? cur : LVW'(cur + LVW'(1));
        top = '0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            nonempty[l] = (r_fill[l] != '0);
            if (r_fill[l] != '0) begin
                top = LVW'(l);
            end
        end
        send_ok = (32'(r_lv) < NUM_LEVELS) && (r_fill[r_lv[LVW-1:0]] != FW'(LEVEL_DEPTH));
        keep    = (r_op != OP_REMOVE) || (r_rdata[ENT_W-1:PAY_W] != r_who);
        tgt     = ((r_op == OP_PROMOTE) && (r_rdata[ENT_W-1:PAY_W] == r_who)
                   && (r_fill[up] != FW'(LEVEL_DEPTH))) ? up : cur;
        wl      = i_cmd.send ? r_lv[LVW-1:0] : tgt;
        rl      = i_cmd.ann_pop ? top : cur;
        wr_en   = (i_cmd.send && send_ok) || (i_cmd.push && keep);
        rd_en   = i_cmd.pop || i_cmd.ann_pop;
        wdata   = i_cmd.send ? {r_who, r_pay} : r_rdata;
        sum     = (FW+1)'(r_head[wl]) + (FW+1)'(r_fill[wl]);
        tail    = (sum >= (FW+1)'(LEVEL_DEPTH)) ? HW'(sum - (FW+1)'(LEVEL_DEPTH)) : HW'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[f_addr(wl, tail)] <= wdata;
        end
        if (rd_en) begin
            r_rdata <= r_mem[f_addr(rl, r_head[rl])];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l] <= '0;
                r_fill[l] <= '0;
            end
            r_ovalid <= 1'b0;
        end else begin
            if (rd_en) begin
                r_head[rl] <= (r_head[rl] == HW'(LEVEL_DEPTH - 1)) ? '0 : HW'(r_head[rl] + HW'(1));
                r_fill[rl] <= FW'(r_fill[rl] - FW'(1));
            end
            if (wr_en) begin
                r_fill[wl] <= FW'(r_fill[wl] + FW'(1));
            end
            if (i_cmd.ann_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_who <= i_sender_id;
            r_lv  <= i_level;
            r_pay <= i_payload;
        end
        if (i_cmd.lvl_start) begin
            r_k <= r_fill[cur];
        end else if (i_cmd.push) begin
            r_k <= FW'(r_k - FW'(1));
        end
        if (i_cmd.ann_pop) begin
            r_alvl  <= top;
            r_alast <= i_cmd.final_pop
                       || ((r_fill[top] == FW'(1)) && ($countones(nonempty) == 1));
        end
        if (i_cmd.ann_emit) begin
            r_osnd  <= r_rdata[ENT_W-1:PAY_W];
            r_opay  <= r_rdata[PAY_W-1:0];
            r_olvl  <= LVL_W'(r_alvl);
            r_olast <= r_alast;
        end
    end

    assign o_stat.fill_zero    = (r_fill[cur] == '0);
    assign o_stat.k_last       = (r_k == FW'(1));
    assign o_stat.any_nonempty = |nonempty;
    assign o_stat.out_free     = !r_ovalid || i_ready;

    assign o_valid       = r_ovalid;
    assign o_out_sender  = r_osnd;
    assign o_out_level   = r_olvl;
    assign o_out_payload = r_opay;
    assign o_last        = r_olast;

endmodule

@@ src/fpmq_ctrl.sv @@
// ----------------------------------------------------------------------------
// fpmq_ctrl
// Controller: accepts items and sequences send, the per-level walks of remove
// and promote, and the announce pop loop.
// ----------------------------------------------------------------------------
module fpmq_ctrl #(
    parameter int NUM_LEVELS = 5,
    parameter int MAX_POPS   = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  fpmq_pkg::t_op              i_operation,
    input  logic [fpmq_pkg::CNT_W-1:0] i_count,
    input  fpmq_pkg::t_stat            i_stat,
    output fpmq_pkg::t_cmd             o_cmd
);
    import fpmq_pkg::*;

    localparam int CW = $clog2(MAX_POPS + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SEND = 7'b0000010,
        S_LVL  = 7'b0000100,
        S_RD   = 7'b0001000,
        S_WR   = 7'b0010000,
        S_ANN  = 7'b0100000,
        S_AOUT = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    t_lvl          r_lvl, n_lvl;
    t_op           r_op, n_op;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          last_lvl;

    always_comb begin
        n_state  = r_state;
        n_lvl    = r_lvl;
        n_op     = r_op;
        n_cnt    = r_cnt;
        o_cmd    = '0;
        o_cmd.lvl = r_lvl;
        o_ready  = (r_state == S_IDLE);
        last_lvl = (r_op == OP_REMOVE) ? (r_lvl == t_lvl'(NUM_LEVELS - 1)) : (r_lvl == '0);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_op       = i_operation;
                    case (i_operation)
                        OP_SEND:    n_state = S_SEND;
                        OP_REMOVE: begin
                            n_lvl   = '0;
                            n_state = S_LVL;
                        end
                        OP_PROMOTE: begin
                            n_lvl   = t_lvl'(NUM_LEVELS - 2);
                            n_state = S_LVL;
                        end
                        default: begin
                            n_cnt   = (32'(i_count) > MAX_POPS) ? CW'(MAX_POPS) : CW'(i_count);
                            n_state = S_ANN;
                        end
                    endcase
                end
            end
            S_SEND: begin
                o_cmd.send = 1'b1;
                n_state    = S_IDLE;
            end
            S_LVL: begin
                o_cmd.lvl_start = 1'b1;
                if (!i_stat.fill_zero) begin
                    n_state = S_RD;
                end else if (last_lvl) begin
                    n_state = S_IDLE;
                end else begin
                    n_lvl = (r_op == OP_REMOVE) ? t_lvl'(r_lvl + 1'b1) : t_lvl'(r_lvl - 1'b1);
                end
            end
            S_RD: begin
                o_cmd.pop = 1'b1;
                n_state   = S_WR;
            end
            S_WR: begin
                o_cmd.push = 1'b1;
                if (!i_stat.k_last) begin
                    n_state = S_RD;
                end else if (last_lvl) begin
                    n_state = S_IDLE;
                end else begin
                    n_lvl   = (r_op == OP_REMOVE) ? t_lvl'(r_lvl + 1'b1) : t_lvl'(r_lvl - 1'b1);
                    n_state = S_LVL;
                end
            end
            S_ANN: begin
                if ((r_cnt == '0) || !i_stat.any_nonempty) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.ann_pop   = 1'b1;
                    o_cmd.final_pop = (r_cnt == CW'(1));
                    n_cnt           = CW'(r_cnt - CW'(1));
                    n_state         = S_AOUT;
                end
            end
            S_AOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.ann_emit = 1'b1;
                    n_state        = S_ANN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lvl   <= '0;
            r_op    <= OP_SEND;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
            r_op    <= n_op;
            r_cnt   <= n_cnt;
        end
    end

endmodule
